/* sv/triangle_phase_oscillator_assert.svh */
// Assertion macros for the triangle phase oscillator.
// TPO_ASSERT_NOW: antecedent implies consequent in the same cycle.
// TPO_ASSERT_NEXT: antecedent implies consequent in the following cycle.
`ifndef TRIANGLE_PHASE_OSCILLATOR_ASSERT_SVH
`define TRIANGLE_PHASE_OSCILLATOR_ASSERT_SVH
`ifndef SYNTH
`define TPO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TPO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TPO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TPO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/tpo_pkg.sv */
package tpo_pkg;

	localparam int SAMPLE_W = 24;
	localparam int PHASE_W  = 32;
	localparam int FREQ_W   = 32;
	localparam int STEP_W   = 32;

	localparam logic [PHASE_W-1:0] QUARTER_CYCLE = 32'h4000_0000;

	localparam logic signed [25:0] SAT_HI = 26'sd8388607;
	localparam logic signed [25:0] SAT_LO = -26'sd8388608;

	localparam logic [1:0]            SOURCE_MODE_RST = 2'd0;
	localparam logic [STEP_W-1:0]     HZ_TO_STEP_RST  = 32'd22906492;
	localparam logic [SAMPLE_W-1:0]   GAIN_CONST_RST  = 24'd1048576;
	localparam logic [SAMPLE_W-1:0]   OFFSET_CONST_RST = 24'd0;

	typedef enum logic [1:0] {
		REG_SOURCE_MODE  = 2'd0,
		REG_HZ_TO_STEP   = 2'd1,
		REG_GAIN_CONST   = 2'd2,
		REG_OFFSET_CONST = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		SRC_ITEM       = 2'd0,
		SRC_OFFSET_REG = 2'd1,
		SRC_BOTH_REG   = 2'd2
	} source_mode_t;

	localparam logic MODE_SAMPLE    = 1'b0;
	localparam logic MODE_SET_PHASE = 1'b1;

endpackage

/* sv/tpo_round_sat.sv */
module tpo_round_sat (
	input  logic signed [47:0]                  prod,
	input  logic signed [tpo_pkg::SAMPLE_W-1:0] offset,
	output logic signed [tpo_pkg::SAMPLE_W-1:0] sample
);

	logic signed [48:0] biased;
	logic signed [25:0] rounded;
	logic signed [25:0] sum;

	// Q5.43 -> Q4.20, round half up
	assign biased  = 49'(prod) + 49'sd4194304;
	assign rounded = biased[48:23];
	assign sum     = rounded + 26'(offset);

	always_comb begin
		if (sum > tpo_pkg::SAT_HI) begin
			sample = tpo_pkg::SAT_HI[tpo_pkg::SAMPLE_W-1:0];
		end else if (sum < tpo_pkg::SAT_LO) begin
			sample = tpo_pkg::SAT_LO[tpo_pkg::SAMPLE_W-1:0];
		end else begin
			sample = sum[tpo_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

/* sv/triangle_phase_oscillator.sv */
// Triangle oscillator on a 32-bit phase accumulator. Each input transfer is either a
// sample step (gives one 24-bit Q4.20 sample from the phase before the step, then
// advances the phase by freq_hz * hz_to_step / 2^24) or a phase set (loads
// phase_value plus a quarter cycle, gives no output). One transfer is taken per clock
// unless the output stalls; a sample passes the input register, step multiply, phase
// accumulate with triangle times gain multiply, round/saturate into the output
// register. The phase loop, a single add in stage 2, fixes the rate at one item per
// cycle. Configuration must be written only while idle; nothing enforces this.
module triangle_phase_oscillator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [0] mode, [32:1] freq_hz, [56:33] gain_in, [80:57] offset_in,
	// [112:81] phase_value, [119:113] zero
	input  logic [119:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [23:0] sample_out
	output logic [23:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int SW = tpo_pkg::SAMPLE_W;
	localparam int PW = tpo_pkg::PHASE_W;

	// configuration registers
	logic [1:0]           source_mode_q;
	logic [31:0]          hz_to_step_q;
	logic signed [SW-1:0] gain_const_q;
	logic signed [SW-1:0] offset_const_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mode_q  <= tpo_pkg::SOURCE_MODE_RST;
			hz_to_step_q   <= tpo_pkg::HZ_TO_STEP_RST;
			gain_const_q   <= tpo_pkg::GAIN_CONST_RST;
			offset_const_q <= tpo_pkg::OFFSET_CONST_RST;
		end else if (cfg_we) begin
			case (tpo_pkg::reg_index_t'(cfg_index))
				tpo_pkg::REG_SOURCE_MODE:  source_mode_q  <= cfg_data[1:0];
				tpo_pkg::REG_HZ_TO_STEP:   hz_to_step_q   <= cfg_data;
				tpo_pkg::REG_GAIN_CONST:   gain_const_q   <= cfg_data[SW-1:0];
				tpo_pkg::REG_OFFSET_CONST: offset_const_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// stall chain
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3, en_out;

	assign en_out   = !m_tvalid || m_tready;
	assign en3      = !v_s3 || en_out;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	// stage 1: input register
	logic                                mode_s1;
	logic signed [tpo_pkg::FREQ_W-1:0]   freq_s1;
	logic signed [SW-1:0]                gain_in_s1;
	logic signed [SW-1:0]                offset_in_s1;
	logic [PW-1:0]                       phase_value_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			mode_s1        <= s_tdata[0];
			freq_s1        <= s_tdata[32:1];
			gain_in_s1     <= s_tdata[56:33];
			offset_in_s1   <= s_tdata[80:57];
			phase_value_s1 <= s_tdata[112:81];
		end
	end

	// stage 1 -> 2: source select and step multiply
	logic signed [SW-1:0] gain_sel;
	logic signed [SW-1:0] offset_sel;
	logic signed [64:0]   step_prod;

	always_comb begin
		case (tpo_pkg::source_mode_t'(source_mode_q))
			tpo_pkg::SRC_ITEM: begin
				gain_sel   = gain_in_s1;
				offset_sel = offset_in_s1;
			end
			tpo_pkg::SRC_OFFSET_REG: begin
				gain_sel   = gain_in_s1;
				offset_sel = offset_const_q;
			end
			default: begin
				gain_sel   = gain_const_q;
				offset_sel = offset_const_q;
			end
		endcase
	end

	assign step_prod = 65'(freq_s1) * 65'($signed({1'b0, hz_to_step_q}));

	logic                 mode_s2;
	logic signed [SW-1:0] gain_s2;
	logic signed [SW-1:0] offset_s2;
	logic [PW-1:0]        step_s2;
	logic [PW-1:0]        phase_value_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			mode_s2        <= mode_s1;
			gain_s2        <= gain_sel;
			offset_s2      <= offset_sel;
			step_s2        <= step_prod[55:24];
			phase_value_s2 <= phase_value_s1;
		end
	end

	// stage 2: phase accumulator, triangle and gain multiply
	logic [PW-1:0]        phase_q;
	logic [PW-1:0]        folded;
	logic signed [SW-1:0] tri_q23;
	logic                 fire_s2;

	assign fire_s2 = v_s2 && en3;
	assign folded  = phase_q[PW-1] ? ~phase_q : phase_q;
	assign tri_q23 = {~folded[30], folded[29:7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tpo_pkg::QUARTER_CYCLE;
		end else if (fire_s2) begin
			if (mode_s2 == tpo_pkg::MODE_SET_PHASE) begin
				phase_q <= phase_value_s2 + tpo_pkg::QUARTER_CYCLE;
			end else begin
				phase_q <= phase_q + step_s2;
			end
		end
	end

	logic signed [47:0]   prod_s3;
	logic signed [SW-1:0] offset_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2 && (mode_s2 == tpo_pkg::MODE_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2) begin
			prod_s3   <= 48'(tri_q23) * 48'(gain_s2);
			offset_s3 <= offset_s2;
		end
	end

	// stage 3: round, offset, saturate into the output register
	logic signed [SW-1:0] sample;

	tpo_round_sat u_round_sat (
		.prod   (prod_s3),
		.offset (offset_s3),
		.sample (sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en_out) begin
			m_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			m_tdata <= sample;
		end
	end

`include "triangle_phase_oscillator_assert.svh"

	`TPO_ASSERT_NEXT(a_set_no_sample, clk, arst_n, fire_s2 && (mode_s2 == tpo_pkg::MODE_SET_PHASE), !v_s3, "phase set produced a sample")
	`TPO_ASSERT_NEXT(a_phase_hold, clk, arst_n, !fire_s2, $stable(phase_q), "phase moved without a stage 2 transfer")
	`TPO_ASSERT_NEXT(a_phase_set, clk, arst_n, fire_s2 && (mode_s2 == tpo_pkg::MODE_SET_PHASE), phase_q == $past(phase_value_s2) + tpo_pkg::QUARTER_CYCLE, "phase set loaded wrong value")
	`TPO_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready, "input stalled with empty output")

endmodule
